>>> rtl/bellows_direction_classifier_top_macros.svh
// assertion macros for the bellows direction classifier
// used by the queue and back-end modules; expects clk and rst in scope
`ifndef BELLOWS_DIRECTION_CLASSIFIER_TOP_MACROS_SVH
`define BELLOWS_DIRECTION_CLASSIFIER_TOP_MACROS_SVH

// property must hold at every edge outside reset
`define BDC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// expression must never be true outside reset
`define BDC_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

>>> rtl/bdc_pkg.sv
// shared types and constants for the bellows direction classifier
// used by every rtl module of the block; no dependencies
`default_nettype none

package bdc_pkg;

  localparam int SAMPLE_W   = 20;
  localparam int LEVEL_W    = 16;
  localparam int INTEN_W    = 17;
  localparam int DIST_W     = 20;
  localparam int EDGE_W     = 19;
  localparam int CMP_W      = 24;
  localparam int REG_IDX_W  = 3;
  localparam int DIV_STEPS  = 16;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [INTEN_W-1:0] INTEN_FULL = INTEN_W'(65536);

  localparam logic [REG_IDX_W-1:0] REG_CENTER    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_DEAD_BAND = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_HYST      = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_FULL_PUSH = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_FULL_PULL = 3'd4;

  localparam logic [LEVEL_W-1:0] CENTER_RST    = 16'd32768;
  localparam logic [LEVEL_W-1:0] DEAD_BAND_RST = 16'd1024;
  localparam logic [LEVEL_W-1:0] HYST_RST      = 16'd256;
  localparam logic [LEVEL_W-1:0] FULL_PUSH_RST = 16'd16384;
  localparam logic [LEVEL_W-1:0] FULL_PULL_RST = 16'd49152;

  typedef enum logic [1:0] {
    DIR_NEUTRAL = 2'd0,
    DIR_PUSH    = 2'd1,
    DIR_PULL    = 2'd2
  } bdc_dir_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_RUN,
    BK_HOLD
  } bdc_state_t;

  // classified word handed from front to back
  typedef struct packed {
    bdc_dir_t            dir;
    logic [DIST_W-1:0]   excess;
    logic [DIST_W-1:0]   span16;
    logic                zero;
  } bdc_job_t;

endpackage

`default_nettype wire

>>> rtl/bdc_front.sv
// front end: configuration registers, edge math and direction state machine
// depends on bdc_pkg; feeds classified words into bdc_queue
`default_nettype none

module bdc_front import bdc_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  wr_en,
  input  wire logic [REG_IDX_W-1:0]  wr_index,
  input  wire logic [LEVEL_W-1:0]    wr_data,
  input  wire logic                  push,
  input  wire logic [SAMPLE_W-1:0]   sample,
  input  wire logic                  q_full,
  output bdc_job_t                   job,
  output logic                       job_wr
);

  logic [LEVEL_W-1:0] center_level;
  logic [LEVEL_W-1:0] dead_band;
  logic [LEVEL_W-1:0] hysteresis;
  logic [LEVEL_W-1:0] full_push_level;
  logic [LEVEL_W-1:0] full_pull_level;
  bdc_dir_t           last_direction;

  logic [LEVEL_W:0]          half;
  logic signed [EDGE_W-1:0]  push_thr;
  logic signed [EDGE_W-1:0]  pull_thr;
  logic signed [EDGE_W-1:0]  push_ret;
  logic signed [EDGE_W-1:0]  pull_ret;
  logic signed [CMP_W-1:0]   s_cmp;
  logic signed [CMP_W-1:0]   push16;
  logic signed [CMP_W-1:0]   pull16;
  logic signed [CMP_W-1:0]   push_ret16;
  logic signed [CMP_W-1:0]   pull_ret16;
  logic signed [CMP_W-1:0]   push_gap;
  logic signed [CMP_W-1:0]   pull_gap;
  logic signed [EDGE_W-1:0]  push_span;
  logic signed [EDGE_W-1:0]  pull_span;
  logic signed [EDGE_W-1:0]  span_sel;
  logic                      below_push;
  logic                      above_pull;
  bdc_dir_t                  dir_new;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_level    <= CENTER_RST;
      dead_band       <= DEAD_BAND_RST;
      hysteresis      <= HYST_RST;
      full_push_level <= FULL_PUSH_RST;
      full_pull_level <= FULL_PULL_RST;
    end else if (wr_en) begin
      case (wr_index)
        REG_CENTER:    center_level    <= wr_data;
        REG_DEAD_BAND: dead_band       <= wr_data;
        REG_HYST:      hysteresis      <= wr_data;
        REG_FULL_PUSH: full_push_level <= wr_data;
        REG_FULL_PULL: full_pull_level <= wr_data;
        default: ;
      endcase
    end
  end

  // edges, each half truncated
  assign half     = {2'b00, dead_band[LEVEL_W-1:1]} + {2'b00, hysteresis[LEVEL_W-1:1]};
  assign push_thr = $signed({3'b000, center_level}) - $signed({2'b00, half});
  assign pull_thr = $signed({3'b000, center_level}) + $signed({2'b00, half});
  assign push_ret = push_thr + $signed({3'b000, hysteresis});
  assign pull_ret = pull_thr - $signed({3'b000, hysteresis});

  assign s_cmp      = $signed({4'b0000, sample});
  assign push16     = $signed({push_thr[EDGE_W-1], push_thr, 4'b0000});
  assign pull16     = $signed({pull_thr[EDGE_W-1], pull_thr, 4'b0000});
  assign push_ret16 = $signed({push_ret[EDGE_W-1], push_ret, 4'b0000});
  assign pull_ret16 = $signed({pull_ret[EDGE_W-1], pull_ret, 4'b0000});

  assign below_push = s_cmp < push16;
  assign above_pull = s_cmp > pull16;

  always_comb begin
    case (last_direction)
      DIR_PUSH: begin
        if (above_pull)                dir_new = DIR_PULL;
        else if (s_cmp >= push_ret16)  dir_new = DIR_NEUTRAL;
        else                           dir_new = DIR_PUSH;
      end
      DIR_PULL: begin
        if (below_push)                dir_new = DIR_PUSH;
        else if (s_cmp <= pull_ret16)  dir_new = DIR_NEUTRAL;
        else                           dir_new = DIR_PULL;
      end
      default: begin
        if (below_push)       dir_new = DIR_PUSH;
        else if (above_pull)  dir_new = DIR_PULL;
        else                  dir_new = DIR_NEUTRAL;
      end
    endcase
  end

  assign push_gap  = push16 - s_cmp;
  assign pull_gap  = s_cmp - pull16;
  assign push_span = push_thr - $signed({3'b000, full_push_level});
  assign pull_span = $signed({3'b000, full_pull_level}) - pull_thr;

  always_comb begin
    job.dir = dir_new;
    case (dir_new)
      DIR_PUSH: begin
        job.excess = below_push ? push_gap[DIST_W-1:0] : '0;
        span_sel   = push_span;
      end
      DIR_PULL: begin
        job.excess = above_pull ? pull_gap[DIST_W-1:0] : '0;
        span_sel   = pull_span;
      end
      default: begin
        job.excess = '0;
        span_sel   = '0;
      end
    endcase
    // a positive span never exceeds 16 bits
    job.span16 = {span_sel[LEVEL_W-1:0], 4'b0000};
    job.zero   = (dir_new == DIR_NEUTRAL) || (span_sel <= 0);
  end

  assign job_wr = push && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_direction <= DIR_NEUTRAL;
    end else if (job_wr) begin
      last_direction <= dir_new;
    end
  end

endmodule

`default_nettype wire

>>> rtl/bdc_queue.sv
// short register queue of classified words between front and back end
// depends on bdc_pkg and the assertion macro header
`default_nettype none
`include "bellows_direction_classifier_top_macros.svh"

module bdc_queue import bdc_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      wr,
  input  wire bdc_job_t  wr_job,
  output logic           full,
  input  wire logic      rd,
  output bdc_job_t       rd_job,
  output logic           empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  bdc_job_t            slots [DEPTH];
  logic [PTR_W-1:0]    wr_ptr;
  logic [PTR_W-1:0]    rd_ptr;
  logic [CNT_W-1:0]    count;
  logic                do_wr;
  logic                do_rd;

  assign full   = count == CNT_W'(DEPTH);
  assign empty  = count == '0;
  assign do_wr  = wr && !full;
  assign do_rd  = rd && !empty;
  assign rd_job = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  `BDC_ASSERT(a_count_bound, count <= CNT_W'(DEPTH), "queue count beyond depth")
  `BDC_ASSERT(a_ptr_gap, (wr_ptr == rd_ptr) == (empty || full), "queue pointers disagree with count")
  `BDC_ASSERT_NEVER(a_wr_when_full, wr && full, "write offered to a full queue")

endmodule

`default_nettype wire

>>> rtl/bdc_back.sv
// back end: serial restoring divider for the intensity and the result register
// depends on bdc_pkg and the assertion macro header; reads words from bdc_queue
`default_nettype none
`include "bellows_direction_classifier_top_macros.svh"

module bdc_back import bdc_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                q_empty,
  input  wire bdc_job_t            q_job,
  output logic                     q_pop,
  output logic                     empty,
  input  wire logic                pop,
  output logic [1:0]               direction,
  output logic [INTEN_W-1:0]       intensity
);

  localparam int CNT_W = $clog2(DIV_STEPS);

  bdc_state_t           state;
  bdc_state_t           state_next;
  logic [CNT_W-1:0]     cnt;
  logic [DIST_W-1:0]    rem;
  logic [DIST_W-1:0]    rem_next;
  logic [DIST_W-1:0]    dvs;
  logic [INTEN_W-1:0]   quo;
  bdc_dir_t             dir_r;
  logic                 out_valid;
  bdc_dir_t             out_dir;
  logic [INTEN_W-1:0]   out_int;
  logic                 out_free;
  logic                 out_load;
  logic                 job_short;
  logic [DIST_W:0]      rem2;
  logic [DIST_W:0]      rem_sub;
  logic                 rem_ge;

  assign out_free  = !out_valid || pop;
  assign job_short = q_job.zero || (q_job.excess >= q_job.span16);

  assign rem2     = {rem, 1'b0};
  assign rem_sub  = rem2 - {1'b0, dvs};
  assign rem_ge   = rem2 >= {1'b0, dvs};
  assign rem_next = rem_ge ? rem_sub[DIST_W-1:0] : rem2[DIST_W-1:0];

  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: begin
        if (!q_empty) begin
          state_next = job_short ? BK_HOLD : BK_RUN;
        end
      end
      BK_RUN: begin
        if (cnt == CNT_W'(DIV_STEPS - 1)) begin
          state_next = BK_HOLD;
        end
      end
      BK_HOLD: begin
        if (out_free) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop    = 1'b0;
    out_load = 1'b0;
    case (state)
      BK_IDLE: q_pop    = !q_empty;
      BK_HOLD: out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      dir_r <= q_job.dir;
      dvs   <= q_job.span16;
      rem   <= q_job.excess;
      cnt   <= '0;
      if (q_job.zero) begin
        quo <= '0;
      end else if (q_job.excess >= q_job.span16) begin
        quo <= INTEN_FULL;
      end else begin
        quo <= '0;
      end
    end else if (state == BK_RUN) begin
      rem <= rem_next;
      quo <= {quo[INTEN_W-2:0], rem_ge};
      cnt <= cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_dir <= dir_r;
      out_int <= quo;
    end
  end

  assign empty     = !out_valid;
  assign direction = out_dir;
  assign intensity = out_int;

  `BDC_ASSERT(a_rem_below_dvs, (state == BK_RUN) |-> (rem < dvs), "divider remainder not below divisor")
  `BDC_ASSERT(a_int_range, out_valid |-> (out_int <= INTEN_FULL), "intensity above full scale")
  `BDC_ASSERT(a_neutral_zero, (out_valid && out_dir == DIR_NEUTRAL) |-> (out_int == '0), "neutral word with nonzero intensity")
  `BDC_ASSERT_NEVER(a_load_overwrite, out_load && out_valid && !pop, "result register overwritten")

endmodule

`default_nettype wire

>>> rtl/bellows_direction_classifier_top.sv
// Bellows direction classifier: sorts 16.4 pressure samples into neutral,
// push or pull with hysteresis and gives a Q1.16 intensity for each one.
//
// Input channel: drive sample with push high; the word is taken at a clock
// edge where push is high and full is low. Results: while empty is low,
// direction and intensity show the oldest result; pop with empty low takes it.
// Configuration: wr_en, wr_index and wr_data write register wr_index at the
// clock edge (0 center, 1 dead band, 2 hysteresis, 3 full push, 4 full pull).
// Write only while no result is outstanding.
//
// The front writes each classified word into the queue; the back end pops
// it, goes straight to its hold state when no division is needed (neutral,
// empty span or at full scale), else runs the 16-step serial divider first,
// and from the hold state loads the result register once that is free. The
// divider limits the sustained rate; the front takes a sample in any cycle
// the classified-word queue (QUEUE_DEPTH words) has room, so short bursts
// enter back to back. When the receiver stalls, the result register holds,
// the divider then holds its finished word, the queue fills and full rises.
// Reset (rst, synchronous) restores register defaults, sets the held
// direction to neutral and empties the queue and result register.
`default_nettype none

module bellows_direction_classifier_top import bdc_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  wr_en,
  input  wire logic [REG_IDX_W-1:0]  wr_index,
  input  wire logic [LEVEL_W-1:0]    wr_data,
  input  wire logic                  push,
  output logic                       full,
  input  wire logic [SAMPLE_W-1:0]   sample,
  output logic                       empty,
  input  wire logic                  pop,
  output logic [1:0]                 direction,
  output logic [INTEN_W-1:0]         intensity
);

  bdc_job_t  front_job;
  logic      front_wr;
  bdc_job_t  head_job;
  logic      q_empty;
  logic      q_pop;

  bdc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .push     (push),
    .sample   (sample),
    .q_full   (full),
    .job      (front_job),
    .job_wr   (front_wr)
  );

  bdc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr     (front_wr),
    .wr_job (front_job),
    .full   (full),
    .rd     (q_pop),
    .rd_job (head_job),
    .empty  (q_empty)
  );

  bdc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_job     (head_job),
    .q_pop     (q_pop),
    .empty     (empty),
    .pop       (pop),
    .direction (direction),
    .intensity (intensity)
  );

endmodule

`default_nettype wire

>>> dv/bellows_direction_classifier_top_test.sv
`timescale 1ns / 1ps
// self-checking testbench for bellows_direction_classifier_top: queued samples go in
// with random bursts and stalls, each result word is checked against a local predictor
// depends on bdc_pkg and the rtl of the block only

module bellows_direction_classifier_top_test;

  import bdc_pkg::*;

  localparam int     QUIET_LIMIT = 2000;
  localparam int     LONG_HOLD   = 400;
  localparam int     DRAIN_PAUSE = 20;
  localparam int     PHASE_ITEMS = 160;
  localparam longint SAMPLE_MAX  = (longint'(1) << SAMPLE_W) - 1;
  localparam longint Q16_SCALE   = 65536;

  typedef struct packed {
    bdc_dir_t           dir;
    logic [INTEN_W-1:0] inten;
  } reading_t;

  typedef enum logic [1:0] {
    DRAIN_ALWAYS,
    DRAIN_MOSTLY,
    DRAIN_RARELY,
    DRAIN_EVERY_THIRD
  } drain_mode_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 wr_en = 1'b0;
  logic [REG_IDX_W-1:0] wr_index = '0;
  logic [LEVEL_W-1:0]   wr_data = '0;
  logic                 push = 1'b0;
  logic                 full;
  logic [SAMPLE_W-1:0]  sample = '0;
  logic                 empty;
  logic                 pop = 1'b0;
  logic [1:0]           direction;
  logic [INTEN_W-1:0]   intensity;

  // local copy of the registers and the held direction
  logic [LEVEL_W-1:0] cfg_center    = CENTER_RST;
  logic [LEVEL_W-1:0] cfg_dead      = DEAD_BAND_RST;
  logic [LEVEL_W-1:0] cfg_hyst      = HYST_RST;
  logic [LEVEL_W-1:0] cfg_full_push = FULL_PUSH_RST;
  logic [LEVEL_W-1:0] cfg_full_pull = FULL_PULL_RST;
  bdc_dir_t           held_dir      = DIR_NEUTRAL;

  logic [SAMPLE_W-1:0] pending_samples[$];
  reading_t            expected_readings[$];

  int queued_count  = 0;
  int samples_taken = 0;
  int results_seen  = 0;
  int error_count   = 0;
  int quiet_cycles  = 0;
  bit in_taken      = 1'b0;
  bit out_taken     = 1'b0;

  int          burst_left = 0;
  int          gap_left   = 0;
  int          mode_left  = 0;
  int          hold_left  = 0;
  int          holds_done = 0;
  drain_mode_t drain_mode = DRAIN_ALWAYS;

  bellows_direction_classifier_top dut (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (wr_en),
    .wr_index  (wr_index),
    .wr_data   (wr_data),
    .push      (push),
    .full      (full),
    .sample    (sample),
    .empty     (empty),
    .pop       (pop),
    .direction (direction),
    .intensity (intensity)
  );

  always #5 clk = ~clk;

  task automatic flag_error(string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    error_count++;
  endtask

  // edges in 1/16 units and the spans to the full-scale levels
  function automatic void current_edges(output longint p16, output longint q16,
                                        output longint pb16, output longint qb16,
                                        output longint ps, output longint qs);
    longint c, hy, half, fp, fl, pe, qe;
    c    = cfg_center;
    hy   = cfg_hyst;
    fp   = cfg_full_push;
    fl   = cfg_full_pull;
    half = cfg_dead >> 1;
    half = half + (cfg_hyst >> 1);
    pe   = c - half;
    qe   = c + half;
    p16  = pe * 16;
    q16  = qe * 16;
    pb16 = (pe + hy) * 16;
    qb16 = (qe - hy) * 16;
    ps   = pe - fp;
    qs   = fl - qe;
  endfunction

  function automatic reading_t classify_sample(logic [SAMPLE_W-1:0] smp);
    longint   s, p16, q16, pb16, qb16, ps, qs, excess, span;
    bdc_dir_t dir;
    reading_t r;
    current_edges(p16, q16, pb16, qb16, ps, qs);
    s = smp;
    case (held_dir)
      DIR_PUSH: begin
        if (s > q16) dir = DIR_PULL;
        else if (s >= pb16) dir = DIR_NEUTRAL;
        else dir = DIR_PUSH;
      end
      DIR_PULL: begin
        if (s < p16) dir = DIR_PUSH;
        else if (s <= qb16) dir = DIR_NEUTRAL;
        else dir = DIR_PULL;
      end
      default: begin
        if (s < p16) dir = DIR_PUSH;
        else if (s > q16) dir = DIR_PULL;
        else dir = DIR_NEUTRAL;
      end
    endcase
    excess = 0;
    span = 0;
    if (dir == DIR_PUSH) begin
      excess = (s < p16) ? p16 - s : 0;
      span = ps;
    end else if (dir == DIR_PULL) begin
      excess = (s > q16) ? s - q16 : 0;
      span = qs;
    end
    r.dir = dir;
    if (span <= 0) r.inten = '0;
    else if (excess >= span * 16) r.inten = INTEN_FULL;
    else r.inten = INTEN_W'((excess * Q16_SCALE) / (span * 16));
    held_dir = dir;
    return r;
  endfunction

  // mostly samples near the edges so that the hysteresis paths get exercised
  function automatic logic [SAMPLE_W-1:0] pick_sample();
    longint p16, q16, pb16, qb16, ps, qs, v, reach;
    current_edges(p16, q16, pb16, qb16, ps, qs);
    reach = ($urandom_range(0, 3) == 0) ? 4096 : 48;
    case ($urandom_range(0, 10))
      0, 1: return SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
      2: return ($urandom_range(0, 1) == 0) ? '0 : SAMPLE_W'(SAMPLE_MAX);
      3: v = p16 - ps * 16;
      4: v = q16 + qs * 16;
      5: v = pb16;
      6: v = qb16;
      7, 8: v = p16;
      default: v = q16;
    endcase
    v = v + longint'($urandom_range(0, 2 * reach)) - reach;
    if (v < 0) v = 0;
    if (v > SAMPLE_MAX) v = SAMPLE_MAX;
    return SAMPLE_W'(v);
  endfunction

  function automatic logic [LEVEL_W-1:0] clip16(longint v);
    if (v < 0) return '0;
    if (v > 65535) return '1;
    return LEVEL_W'(v);
  endfunction

  task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [LEVEL_W-1:0] val);
    @(negedge clk);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= val;
    case (idx)
      REG_CENTER:    cfg_center    = val;
      REG_DEAD_BAND: cfg_dead      = val;
      REG_HYST:      cfg_hyst      = val;
      REG_FULL_PUSH: cfg_full_push = val;
      REG_FULL_PULL: cfg_full_pull = val;
      default: ;
    endcase
    @(negedge clk);
    wr_en <= 1'b0;
  endtask

  task automatic apply_levels(longint c, longint d, longint h, longint fp, longint fl);
    write_reg(REG_CENTER, clip16(c));
    write_reg(REG_DEAD_BAND, clip16(d));
    write_reg(REG_HYST, clip16(h));
    write_reg(REG_FULL_PUSH, clip16(fp));
    write_reg(REG_FULL_PULL, clip16(fl));
  endtask

  task automatic run_phase(int count);
    for (int i = 0; i < count; i++) begin
      pending_samples.push_back(pick_sample());
      queued_count++;
    end
    while (samples_taken < queued_count || expected_readings.size() != 0) @(posedge clk);
    repeat (DRAIN_PAUSE) @(posedge clk);
  endtask

  // sender: bursts of random length with random gaps
  always @(negedge clk) begin : feed
    logic                next_push;
    logic [SAMPLE_W-1:0] next_sample;
    next_push   = push;
    next_sample = sample;
    if (rst) begin
      next_push = 1'b0;
    end else if (!push || in_taken) begin
      next_push = 1'b0;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
      end
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_samples.size() != 0) begin
        next_push   = 1'b1;
        next_sample = pending_samples.pop_front();
        burst_left--;
      end
    end
    push   <= next_push;
    sample <= next_sample;
  end

  // receiver: stall pattern of its own plus long hold-offs while samples keep coming
  always @(negedge clk) begin : drain
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        drain_mode = drain_mode_t'($urandom_range(0, 3));
        mode_left  = $urandom_range(32, 256);
      end
      mode_left--;
      if (hold_left == 0 && holds_done < 2 && results_seen >= 300 + 700 * holds_done
          && pending_samples.size() >= 40) begin
        hold_left = LONG_HOLD;
        holds_done++;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        case (drain_mode)
          DRAIN_ALWAYS: pop <= 1'b1;
          DRAIN_MOSTLY: pop <= ($urandom_range(0, 3) != 0);
          DRAIN_RARELY: pop <= ($urandom_range(0, 3) == 0);
          default:      pop <= (mode_left % 3 == 0);
        endcase
      end
    end
  end

  // monitor: predict on every accepted sample, check every accepted word
  always @(posedge clk) begin : observe
    reading_t want;
    in_taken  = 1'b0;
    out_taken = 1'b0;
    if (!rst) begin
      if (pop && !empty) begin
        out_taken = 1'b1;
        results_seen++;
        if (expected_readings.size() == 0) begin
          flag_error($sformatf("unexpected word dir=%0d inten=%0d", direction, intensity));
        end else begin
          want = expected_readings.pop_front();
          if (direction !== want.dir)
            flag_error($sformatf("word %0d direction %0d, want %0d",
                                 results_seen, direction, want.dir));
          if (intensity !== want.inten)
            flag_error($sformatf("word %0d intensity %0d, want %0d",
                                 results_seen, intensity, want.inten));
        end
      end
      if (push && !full) begin
        in_taken = 1'b1;
        samples_taken++;
        expected_readings.push_back(classify_sample(sample));
      end
    end
    if (in_taken || out_taken) quiet_cycles = 0;
    else quiet_cycles++;
  end

  initial begin : watchdog
    while (quiet_cycles < QUIET_LIMIT) @(negedge clk);
    $display("timeout: no word moved for %0d cycles", QUIET_LIMIT);
    $display("** bellows_direction_classifier_top: FAILED **");
    $finish;
  end

  initial begin : stimulus
    longint p16, q16, pb16, qb16, ps, qs;
    longint c, d, h, half;
    longint directed_pts[$];
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset values: edges, hysteresis returns, direct crossings, intensity points
    current_edges(p16, q16, pb16, qb16, ps, qs);
    directed_pts = '{0, p16 - 1, p16, pb16 - 1, pb16, p16, q16, q16 + 1, qb16 + 1, qb16,
                     SAMPLE_MAX, 0, SAMPLE_MAX, (p16 + q16) / 2, p16 - 8 * ps,
                     p16 - 16 * ps, p16 - 16 * ps + 1, q16 + 16 * qs - 1, q16 + 16 * qs,
                     20'h55555, 20'hAAAAA, (p16 + q16) / 2};
    foreach (directed_pts[i]) begin
      pending_samples.push_back(SAMPLE_W'(directed_pts[i]));
      queued_count++;
    end
    run_phase(PHASE_ITEMS - directed_pts.size());

    for (int p = 0; p < 9; p++) begin
      if (p == 6) begin
        for (int i = REG_FULL_PULL + 1; i < (1 << REG_IDX_W); i++)
          write_reg(REG_IDX_W'(i), LEVEL_W'($urandom));
      end
      c = $urandom_range(12000, 54000);
      d = $urandom_range(0, 4000);
      h = $urandom_range(0, 2000);
      half = d / 2 + h / 2;
      case (p)
        0, 6: apply_levels(c, d, h, c - half - $urandom_range(1, 300),
                           c + half + $urandom_range(1, 300));
        1: apply_levels(0, 0, 0, 0, 0);
        2: apply_levels(65535, 65535, 65535, 65535, 65535);
        3: apply_levels(0, 65535, 65535, 0, 65535);
        4: apply_levels(65535, 0, 0, 65535, 0);
        // full-scale levels inside the edges: empty or negative spans
        5: apply_levels(c, d, h, c + 100, c - 100);
        7: apply_levels(c, d, h, c - half - 1, c + half + 1);
        default: apply_levels($urandom_range(0, 65535), $urandom_range(0, 65535),
                              $urandom_range(0, 65535), $urandom_range(0, 65535),
                              $urandom_range(0, 65535));
      endcase
      run_phase(PHASE_ITEMS);
    end

    if (error_count == 0) $display("** bellows_direction_classifier_top: PASSED **");
    else $display("** bellows_direction_classifier_top: FAILED **");
    $finish;
  end

endmodule
